// ===== design/todca_pkg.sv =====
package todca_pkg;

    // Time-of-day radices
    localparam int unsigned SEC_PER_MIN  = 60;
    localparam int unsigned MIN_PER_HOUR = 60;
    localparam int unsigned HOUR_PER_DAY = 24;
    localparam int unsigned MAX_HOUR     = 23;
    localparam int unsigned MAX_MIN      = 59;
    localparam int unsigned MAX_SEC      = 59;
    localparam int unsigned SEC_PER_HOUR = SEC_PER_MIN * MIN_PER_HOUR;
    localparam int unsigned SEC_PER_DAY  = SEC_PER_HOUR * HOUR_PER_DAY;
    localparam int unsigned MIN_PER_DAY  = MIN_PER_HOUR * HOUR_PER_DAY;

    // Field widths
    localparam int CMD_W    = 3;
    localparam int UNIT_W   = 2;
    localparam int AMOUNT_W = 32;
    localparam int MAG_W    = AMOUNT_W - 1;
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;
    localparam int DAYS_W   = 27;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ADD   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SUB   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SET   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CMP   = 3'd4;

    // Unit codes
    localparam logic [UNIT_W-1:0] UNIT_SEC  = 2'd0;
    localparam logic [UNIT_W-1:0] UNIT_MIN  = 2'd1;
    localparam logic [UNIT_W-1:0] UNIT_HOUR = 2'd2;
    localparam logic [UNIT_W-1:0] UNIT_NONE = 2'd3;

    // Whole days out of a 31-bit count: q = (x * RCP) >> SHF, exact for x < 2^31
    localparam int unsigned SHF_DAY_SEC  = 48;
    localparam int unsigned SHF_DAY_MIN  = 42;
    localparam int unsigned SHF_DAY_HOUR = 36;
    localparam logic [31:0] RCP_DAY_SEC  =
        32'(((64'd1 << SHF_DAY_SEC) + 64'(SEC_PER_DAY) - 64'd1) / 64'(SEC_PER_DAY));
    localparam logic [31:0] RCP_DAY_MIN  =
        32'(((64'd1 << SHF_DAY_MIN) + 64'(MIN_PER_DAY) - 64'd1) / 64'(MIN_PER_DAY));
    localparam logic [31:0] RCP_DAY_HOUR =
        32'(((64'd1 << SHF_DAY_HOUR) + 64'(HOUR_PER_DAY) - 64'd1) / 64'(HOUR_PER_DAY));

    // Hours out of the 17-bit remainder within a day
    localparam int REM_W = 17;
    localparam int unsigned SHF_HR_SEC  = 29;
    localparam int unsigned SHF_HR_MIN  = 23;
    localparam int unsigned SHF_HR_HOUR = 17;
    localparam logic [17:0] RCP_HR_SEC  =
        18'(((64'd1 << SHF_HR_SEC) + 64'(SEC_PER_HOUR) - 64'd1) / 64'(SEC_PER_HOUR));
    localparam logic [17:0] RCP_HR_MIN  =
        18'(((64'd1 << SHF_HR_MIN) + 64'(MIN_PER_HOUR) - 64'd1) / 64'(MIN_PER_HOUR));
    localparam logic [17:0] RCP_HR_HOUR = 18'(64'd1 << SHF_HR_HOUR);

    // Minutes out of the 12-bit remainder within an hour
    localparam int REM2_W = 12;
    localparam int unsigned SHF_MN_SEC  = 18;
    localparam int unsigned SHF_MN_ONE  = 12;
    localparam logic [12:0] RCP_MN_SEC  =
        13'(((64'd1 << SHF_MN_SEC) + 64'(SEC_PER_MIN) - 64'd1) / 64'(SEC_PER_MIN));
    localparam logic [12:0] RCP_MN_ONE  = 13'(64'd1 << SHF_MN_ONE);

    // Queue between front and back
    localparam int QDEPTH = 8;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [3:0] {
        OP_NOP,
        OP_REJECT,
        OP_ADD,
        OP_SUB,
        OP_SET_H,
        OP_SET_M,
        OP_SET_S,
        OP_CLEAR,
        OP_CMP
    } op_t;

    // Classified command with the count already split into days:h:m:s
    typedef struct packed {
        op_t               op;
        logic [DAYS_W-1:0] days;
        logic [HOUR_W-1:0] dh;
        logic [MIN_W-1:0]  dm;
        logic [SEC_W-1:0]  ds;
        logic [MIN_W-1:0]  set_val;
        logic [HOUR_W-1:0] oh;
        logic [MIN_W-1:0]  om;
        logic [SEC_W-1:0]  os;
    } item_t;

endpackage

// ===== design/todca_req_if.sv =====
interface todca_req_if import todca_pkg::*; ();

    logic                       valid;
    logic                       ready;
    logic [CMD_W-1:0]           cmd;
    logic [UNIT_W-1:0]          unit;
    logic signed [AMOUNT_W-1:0] amount;
    logic [HOUR_W-1:0]          other_hour;
    logic [MIN_W-1:0]           other_minute;
    logic [SEC_W-1:0]           other_second;

    modport source (
        output valid, cmd, unit, amount, other_hour, other_minute, other_second,
        input  ready
    );

    modport sink (
        input  valid, cmd, unit, amount, other_hour, other_minute, other_second,
        output ready
    );

endinterface

// ===== design/todca_rsp_if.sv =====
interface todca_rsp_if import todca_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [HOUR_W-1:0] now_hour;
    logic [MIN_W-1:0]  now_minute;
    logic [SEC_W-1:0]  now_second;
    logic [DAYS_W-1:0] day_carry;
    logic              is_before;
    logic              is_equal;
    logic              is_after;
    logic              rejected;

    modport source (
        output valid, now_hour, now_minute, now_second, day_carry,
               is_before, is_equal, is_after, rejected,
        input  ready
    );

    modport sink (
        input  valid, now_hour, now_minute, now_second, day_carry,
               is_before, is_equal, is_after, rejected,
        output ready
    );

endinterface

// ===== design/todca_front.sv =====
module todca_front import todca_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    todca_req_if.sink   req,
    input  logic        pop,
    output logic        push,
    output item_t       item
);

    localparam int NSTG = 6;

    typedef struct packed {
        op_t               op;
        logic [UNIT_W-1:0] unit;
        logic [MIN_W-1:0]  set_val;
        logic [HOUR_W-1:0] oh;
        logic [MIN_W-1:0]  om;
        logic [SEC_W-1:0]  os;
    } ctx_t;

    logic              fire;
    logic [QCNT_W-1:0] used_reg;
    logic [QCNT_W-1:0] used_next;
    logic [NSTG-1:0]   vld_reg;
    logic [NSTG-1:0]   vld_next;
    ctx_t              ctx_in;
    ctx_t              ctx_reg [NSTG];
    logic [MAG_W-1:0]  mag;

    // stage 1
    logic [MAG_W-1:0]        amt1_reg;
    logic [MAG_W+31:0]       p1_next;
    logic [MAG_W+31:0]       p1_reg;
    logic [31:0]             rcp_day;
    // stage 2
    logic [MAG_W+31:0]       p1_sh;
    logic [DAYS_W-1:0]       q2_next;
    logic [DAYS_W-1:0]       q2_reg;
    logic [REM_W-1:0]        div_day;
    logic [MAG_W-1:0]        qn2_next;
    logic [MAG_W-1:0]        qn2_reg;
    logic [MAG_W-1:0]        amt2_reg;
    // stage 3
    logic [REM_W-1:0]        r3_next;
    logic [REM_W-1:0]        r3_reg;
    logic [17:0]             rcp_hr;
    logic [REM_W+17:0]       p3_next;
    logic [REM_W+17:0]       p3_reg;
    logic [DAYS_W-1:0]       q3_reg;
    // stage 4
    logic [REM_W+17:0]       p3_sh;
    logic [HOUR_W-1:0]       hr4_next;
    logic [HOUR_W-1:0]       hr4_reg;
    logic [REM2_W-1:0]       div_hr;
    logic [REM_W-1:0]        hn4_next;
    logic [REM_W-1:0]        hn4_reg;
    logic [REM_W-1:0]        r4_reg;
    logic [DAYS_W-1:0]       q4_reg;
    // stage 5
    logic [REM2_W-1:0]       r5_next;
    logic [REM2_W-1:0]       r5_reg;
    logic [12:0]             rcp_mn;
    logic [REM2_W+12:0]      p5_next;
    logic [REM2_W+12:0]      p5_reg;
    logic [HOUR_W-1:0]       hr5_reg;
    logic [DAYS_W-1:0]       q5_reg;
    // stage 6
    logic [REM2_W+12:0]      p5_sh;
    logic [MIN_W-1:0]        mn6_next;
    logic [MIN_W-1:0]        mn6_reg;
    logic [MIN_W-1:0]        div_mn;
    logic [REM2_W-1:0]       mns6_next;
    logic [REM2_W-1:0]       mns6_reg;
    logic [REM2_W-1:0]       r6_reg;
    logic [HOUR_W-1:0]       hr6_reg;
    logic [DAYS_W-1:0]       q6_reg;

    // Credit: items accepted and not yet taken by the back end
    assign req.ready = (used_reg < QCNT_W'(QDEPTH));
    assign fire      = req.valid && req.ready;
    assign used_next = used_reg + QCNT_W'(fire) - QCNT_W'(pop);
    assign vld_next  = {vld_reg[NSTG-2:0], fire};
    assign mag       = req.amount[MAG_W-1:0];

    // Classify the command
    always_comb
    begin
        ctx_in.unit    = req.unit;
        ctx_in.set_val = req.amount[MIN_W-1:0];
        ctx_in.oh      = req.other_hour;
        ctx_in.om      = req.other_minute;
        ctx_in.os      = req.other_second;
        unique case (req.cmd)
            CMD_ADD:
                ctx_in.op = (req.amount[AMOUNT_W-1] || req.unit == UNIT_NONE)
                            ? OP_REJECT : OP_ADD;
            CMD_SUB:
                ctx_in.op = (req.amount[AMOUNT_W-1] || req.unit == UNIT_NONE)
                            ? OP_REJECT : OP_SUB;
            CMD_SET:
            begin
                if (req.amount[AMOUNT_W-1])
                begin
                    ctx_in.op = OP_REJECT;
                end
                else
                begin
                    unique case (req.unit)
                        UNIT_HOUR: ctx_in.op = (mag > MAG_W'(MAX_HOUR)) ? OP_REJECT : OP_SET_H;
                        UNIT_MIN:  ctx_in.op = (mag > MAG_W'(MAX_MIN))  ? OP_REJECT : OP_SET_M;
                        UNIT_SEC:  ctx_in.op = (mag > MAG_W'(MAX_SEC))  ? OP_REJECT : OP_SET_S;
                        default:   ctx_in.op = OP_REJECT;
                    endcase
                end
            end
            CMD_CLEAR: ctx_in.op = OP_CLEAR;
            CMD_CMP:   ctx_in.op = OP_CMP;
            default:   ctx_in.op = OP_NOP;
        endcase
    end

    // Stage 1: count times reciprocal of the unit's day length
    always_comb
    begin
        unique case (req.unit)
            UNIT_SEC: rcp_day = RCP_DAY_SEC;
            UNIT_MIN: rcp_day = RCP_DAY_MIN;
            default:  rcp_day = RCP_DAY_HOUR;
        endcase
        p1_next = (MAG_W + 32)'(mag) * (MAG_W + 32)'(rcp_day);
    end

    // Stage 2: whole days and their length in units
    always_comb
    begin
        unique case (ctx_reg[0].unit)
            UNIT_SEC:
            begin
                p1_sh   = p1_reg >> SHF_DAY_SEC;
                div_day = REM_W'(SEC_PER_DAY);
            end
            UNIT_MIN:
            begin
                p1_sh   = p1_reg >> SHF_DAY_MIN;
                div_day = REM_W'(MIN_PER_DAY);
            end
            default:
            begin
                p1_sh   = p1_reg >> SHF_DAY_HOUR;
                div_day = REM_W'(HOUR_PER_DAY);
            end
        endcase
        q2_next  = p1_sh[DAYS_W-1:0];
        qn2_next = MAG_W'(q2_next * div_day);
    end

    // Stage 3: remainder within a day, times reciprocal of the hour length
    always_comb
    begin
        r3_next = REM_W'(amt2_reg - qn2_reg);
        unique case (ctx_reg[1].unit)
            UNIT_SEC: rcp_hr = RCP_HR_SEC;
            UNIT_MIN: rcp_hr = RCP_HR_MIN;
            default:  rcp_hr = RCP_HR_HOUR;
        endcase
        p3_next = (REM_W + 18)'(r3_next) * (REM_W + 18)'(rcp_hr);
    end

    // Stage 4: hours and their length in units
    always_comb
    begin
        unique case (ctx_reg[2].unit)
            UNIT_SEC:
            begin
                p3_sh  = p3_reg >> SHF_HR_SEC;
                div_hr = REM2_W'(SEC_PER_HOUR);
            end
            UNIT_MIN:
            begin
                p3_sh  = p3_reg >> SHF_HR_MIN;
                div_hr = REM2_W'(MIN_PER_HOUR);
            end
            default:
            begin
                p3_sh  = p3_reg >> SHF_HR_HOUR;
                div_hr = REM2_W'(1);
            end
        endcase
        hr4_next = p3_sh[HOUR_W-1:0];
        hn4_next = REM_W'(hr4_next * div_hr);
    end

    // Stage 5: remainder within an hour, times reciprocal of the minute length
    always_comb
    begin
        r5_next = REM2_W'(r4_reg - hn4_reg);
        unique case (ctx_reg[3].unit)
            UNIT_SEC: rcp_mn = RCP_MN_SEC;
            default:  rcp_mn = RCP_MN_ONE;
        endcase
        p5_next = (REM2_W + 13)'(r5_next) * (REM2_W + 13)'(rcp_mn);
    end

    // Stage 6: minutes and their length in units
    always_comb
    begin
        unique case (ctx_reg[4].unit)
            UNIT_SEC:
            begin
                p5_sh  = p5_reg >> SHF_MN_SEC;
                div_mn = MIN_W'(SEC_PER_MIN);
            end
            default:
            begin
                p5_sh  = p5_reg >> SHF_MN_ONE;
                div_mn = MIN_W'(1);
            end
        endcase
        mn6_next  = p5_sh[MIN_W-1:0];
        mns6_next = REM2_W'(mn6_next * div_mn);
    end

    // Hand the split count to the queue
    assign push         = vld_reg[NSTG-1];
    assign item.op      = ctx_reg[NSTG-1].op;
    assign item.days    = q6_reg;
    assign item.dh      = hr6_reg;
    assign item.dm      = mn6_reg;
    assign item.ds      = SEC_W'(r6_reg - mns6_reg);
    assign item.set_val = ctx_reg[NSTG-1].set_val;
    assign item.oh      = ctx_reg[NSTG-1].oh;
    assign item.om      = ctx_reg[NSTG-1].om;
    assign item.os      = ctx_reg[NSTG-1].os;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            vld_reg  <= '0;
        end
        else
        begin
            used_reg <= used_next;
            vld_reg  <= vld_next;
        end
    end

    // Payload advances every cycle; valid bits mark live stages
    always_ff @(posedge clk)
    begin
        ctx_reg[0] <= ctx_in;
        for (int i = 1; i < NSTG; i++)
        begin
            ctx_reg[i] <= ctx_reg[i-1];
        end
        amt1_reg <= mag;
        p1_reg   <= p1_next;
        q2_reg   <= q2_next;
        qn2_reg  <= qn2_next;
        amt2_reg <= amt1_reg;
        q3_reg   <= q2_reg;
        r3_reg   <= r3_next;
        p3_reg   <= p3_next;
        q4_reg   <= q3_reg;
        r4_reg   <= r3_reg;
        hr4_reg  <= hr4_next;
        hn4_reg  <= hn4_next;
        q5_reg   <= q4_reg;
        hr5_reg  <= hr4_reg;
        r5_reg   <= r5_next;
        p5_reg   <= p5_next;
        q6_reg   <= q5_reg;
        hr6_reg  <= hr5_reg;
        r6_reg   <= r5_reg;
        mn6_reg  <= mn6_next;
        mns6_reg <= mns6_next;
    end

endmodule

// ===== design/todca_queue.sv =====
module todca_queue import todca_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t wdata,
    input  logic  pop,
    output item_t rdata,
    output logic  nonempty
);

    item_t             mem [QDEPTH];
    logic [QPTR_W-1:0] wr_reg;
    logic [QPTR_W-1:0] wr_next;
    logic [QPTR_W-1:0] rd_reg;
    logic [QPTR_W-1:0] rd_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic              hv_reg;
    logic              hv_next;
    item_t             head_reg;
    logic              load;
    logic              from_mem;
    logic              bypass;
    logic              wr_en;

    // The head register is free when empty or being popped; refill it from
    // the memory first, else straight from an incoming push
    assign load     = !hv_reg || pop;
    assign from_mem = load && (cnt_reg != '0);
    assign bypass   = load && (cnt_reg == '0) && push;
    assign wr_en    = push && !bypass;
    assign wr_next  = wr_en    ? wr_reg + QPTR_W'(1) : wr_reg;
    assign rd_next  = from_mem ? rd_reg + QPTR_W'(1) : rd_reg;
    assign cnt_next = cnt_reg + QCNT_W'(wr_en) - QCNT_W'(from_mem);
    assign hv_next  = load ? (from_mem || push) : 1'b1;
    assign nonempty = hv_reg;
    assign rdata    = head_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
            hv_reg  <= 1'b0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
            hv_reg  <= hv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_reg] <= wdata;
        end
        if (from_mem)
        begin
            head_reg <= mem[rd_reg];
        end
        else if (bypass)
        begin
            head_reg <= wdata;
        end
    end

endmodule

// ===== design/todca_back.sv =====
module todca_back import todca_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  item_t       head,
    output logic        pop,
    todca_rsp_if.source rsp
);

    logic [HOUR_W-1:0] hour_reg;
    logic [HOUR_W-1:0] hour_next;
    logic [MIN_W-1:0]  minute_reg;
    logic [MIN_W-1:0]  minute_next;
    logic [SEC_W-1:0]  second_reg;
    logic [SEC_W-1:0]  second_next;
    logic              ovld_reg;
    logic              ovld_next;
    logic [DAYS_W-1:0] days_reg;
    logic [DAYS_W-1:0] days_next;
    logic              before_reg;
    logic              before_next;
    logic              equal_reg;
    logic              equal_next;
    logic              after_reg;
    logic              after_next;
    logic              rej_reg;
    logic              rej_next;

    logic [SEC_W:0]    s_sum;
    logic [MIN_W:0]    m_sum;
    logic [HOUR_W:0]   h_sum;
    logic              cs;
    logic              cm;
    logic              cd;
    logic [SEC_W:0]    s_dif;
    logic [MIN_W:0]    m_dif;
    logic [HOUR_W:0]   h_dif;
    logic              bs;
    logic              bm;
    logic              bd;
    logic [SEC_W-1:0]  s_add;
    logic [MIN_W-1:0]  m_add;
    logic [HOUR_W-1:0] h_add;
    logic [SEC_W-1:0]  s_sub;
    logic [MIN_W-1:0]  m_sub;
    logic [HOUR_W-1:0] h_sub;
    logic [HOUR_W+MIN_W+SEC_W-1:0] cur_time;
    logic [HOUR_W+MIN_W+SEC_W-1:0] oth_time;

    // Take the next item when the output register is free or being drained
    assign pop = head_valid && (!ovld_reg || rsp.ready);

    // Mixed-radix add with carry
    always_comb
    begin
        s_sum = (SEC_W + 1)'(second_reg) + (SEC_W + 1)'(head.ds);
        cs    = (s_sum >= (SEC_W + 1)'(SEC_PER_MIN));
        s_add = cs ? SEC_W'(s_sum - (SEC_W + 1)'(SEC_PER_MIN)) : s_sum[SEC_W-1:0];
        m_sum = (MIN_W + 1)'(minute_reg) + (MIN_W + 1)'(head.dm) + (MIN_W + 1)'(cs);
        cm    = (m_sum >= (MIN_W + 1)'(MIN_PER_HOUR));
        m_add = cm ? MIN_W'(m_sum - (MIN_W + 1)'(MIN_PER_HOUR)) : m_sum[MIN_W-1:0];
        h_sum = (HOUR_W + 1)'(hour_reg) + (HOUR_W + 1)'(head.dh) + (HOUR_W + 1)'(cm);
        cd    = (h_sum >= (HOUR_W + 1)'(HOUR_PER_DAY));
        h_add = cd ? HOUR_W'(h_sum - (HOUR_W + 1)'(HOUR_PER_DAY)) : h_sum[HOUR_W-1:0];
    end

    // Mixed-radix subtract with borrow
    always_comb
    begin
        s_dif = (SEC_W + 1)'(second_reg) - (SEC_W + 1)'(head.ds);
        bs    = s_dif[SEC_W];
        s_sub = bs ? SEC_W'(s_dif + (SEC_W + 1)'(SEC_PER_MIN)) : s_dif[SEC_W-1:0];
        m_dif = (MIN_W + 1)'(minute_reg) - (MIN_W + 1)'(head.dm) - (MIN_W + 1)'(bs);
        bm    = m_dif[MIN_W];
        m_sub = bm ? MIN_W'(m_dif + (MIN_W + 1)'(MIN_PER_HOUR)) : m_dif[MIN_W-1:0];
        h_dif = (HOUR_W + 1)'(hour_reg) - (HOUR_W + 1)'(head.dh) - (HOUR_W + 1)'(bm);
        bd    = h_dif[HOUR_W];
        h_sub = bd ? HOUR_W'(h_dif + (HOUR_W + 1)'(HOUR_PER_DAY)) : h_dif[HOUR_W-1:0];
    end

    assign cur_time = {hour_reg, minute_reg, second_reg};
    assign oth_time = {head.oh, head.om, head.os};

    always_comb
    begin
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        days_next   = '0;
        before_next = 1'b0;
        equal_next  = 1'b0;
        after_next  = 1'b0;
        rej_next    = 1'b0;
        ovld_next   = pop ? 1'b1 : (ovld_reg && !rsp.ready);
        if (pop)
        begin
            unique case (head.op)
                OP_ADD:
                begin
                    hour_next   = h_add;
                    minute_next = m_add;
                    second_next = s_add;
                    days_next   = head.days + DAYS_W'(cd);
                end
                OP_SUB:
                begin
                    hour_next   = h_sub;
                    minute_next = m_sub;
                    second_next = s_sub;
                    days_next   = head.days + DAYS_W'(bd);
                end
                OP_SET_H: hour_next   = head.set_val[HOUR_W-1:0];
                OP_SET_M: minute_next = head.set_val;
                OP_SET_S: second_next = head.set_val[SEC_W-1:0];
                OP_CLEAR:
                begin
                    hour_next   = '0;
                    minute_next = '0;
                    second_next = '0;
                end
                OP_CMP:
                begin
                    before_next = (cur_time < oth_time);
                    equal_next  = (cur_time == oth_time);
                    after_next  = (cur_time > oth_time);
                end
                OP_REJECT: rej_next = 1'b1;
                default:   rej_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hour_reg   <= '0;
            minute_reg <= '0;
            second_reg <= '0;
            ovld_reg   <= 1'b0;
        end
        else
        begin
            hour_reg   <= hour_next;
            minute_reg <= minute_next;
            second_reg <= second_next;
            ovld_reg   <= ovld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            days_reg   <= days_next;
            before_reg <= before_next;
            equal_reg  <= equal_next;
            after_reg  <= after_next;
            rej_reg    <= rej_next;
        end
    end

    // Time fields only change on a pop, which also loads the result
    assign rsp.valid      = ovld_reg;
    assign rsp.now_hour   = hour_reg;
    assign rsp.now_minute = minute_reg;
    assign rsp.now_second = second_reg;
    assign rsp.day_carry  = days_reg;
    assign rsp.is_before  = before_reg;
    assign rsp.is_equal   = equal_reg;
    assign rsp.is_after   = after_reg;
    assign rsp.rejected   = rej_reg;

endmodule

// ===== design/time_of_day_clock_arith_core.sv =====
// Channel  Side  Handshake     Payload
// req      in    valid/ready   cmd, unit, amount, other_hour, other_minute, other_second
// rsp      out   valid/ready   now_hour, now_minute, now_second, day_carry,
//                              is_before, is_equal, is_after, rejected
//
// One transfer per cycle on each channel, sustained while rsp is not stalled; a
// command's result is presented on rsp after passing six front stages, the queue
// head and the output register.
// The count split into days:h:m:s runs in the front pipeline; the clock
// registers are updated by a combinational mixed-radix add/subtract in the back end.
// Reset (rst_n low, asynchronous) clears the time to 00:00:00 and empties both parts.
// When rsp stalls, the front keeps filling the 8-entry queue; req.ready drops
// once 8 commands are outstanding between req transfer and back-end pickup.
module time_of_day_clock_arith_core import todca_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    todca_req_if.sink   req,
    todca_rsp_if.source rsp
);

    // front -> queue
    logic  push;
    item_t push_item;

    // queue -> back
    logic  head_valid;
    item_t head;
    logic  pop;

    // Classify commands and split the count into whole days plus h:m:s
    todca_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .pop   (pop),
        .push  (push),
        .item  (push_item)
    );

    // Decouple the front pipeline from the clock update; the front's credit
    // count keeps the queue from overflowing
    todca_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wdata    (push_item),
        .pop      (pop),
        .rdata    (head),
        .nonempty (head_valid)
    );

    // Apply the command to the clock registers and hold the result
    todca_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .rsp        (rsp)
    );

endmodule
